// ===== hdl/bga_pkg.sv =====
// Shared constants, types and state encoding for the battery gauge averager.
package bga_pkg;

  localparam int ADC_BITS     = 12;
  localparam int WINDOW       = 8;
  localparam int WIN_LOG2     = $clog2(WINDOW);
  localparam int SUM_W        = ADC_BITS + WIN_LOG2;
  localparam int MV_W         = 14;
  localparam int PCT_W        = 7;
  localparam int DIVR_W       = 3;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 14;

  localparam int VREF_MV      = 3300;
  localparam int SAMPLE_MAX   = (1 << ADC_BITS) - 1;
  localparam int MV_MAX       = (1 << MV_W) - 1;
  localparam int FULL_PERCENT = 100;

  // Scale is VREF_MV times the divider ratio, kept ready in the config block.
  localparam int SCALE_W      = $clog2(VREF_MV * ((1 << DIVR_W) - 1) + 1);
  localparam int PROD_W       = ADC_BITS + SCALE_W;

  // Percent division: dividend is (mv - empty) * 100, divisor full - empty.
  localparam int DVD_W        = MV_W + $clog2(FULL_PERCENT + 1);
  localparam int REM_W        = MV_W + 1;
  localparam int DIV_STEPS    = DVD_W;
  localparam int CNT_W        = $clog2(DIV_STEPS);

  localparam logic [CFG_IDX_W-1:0] REG_DIVIDER  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FULL     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EMPTY    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LOW      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CRITICAL = 3'd4;

  localparam logic [DIVR_W-1:0] DIVIDER_RESET  = 3'd2;
  localparam logic [MV_W-1:0]   FULL_RESET     = 14'd4200;
  localparam logic [MV_W-1:0]   EMPTY_RESET    = 14'd3000;
  localparam logic [MV_W-1:0]   LOW_RESET      = 14'd3500;
  localparam logic [MV_W-1:0]   CRITICAL_RESET = 14'd3300;

  typedef struct packed {
    logic [SCALE_W-1:0] scale;
    logic [MV_W-1:0]    full_mv;
    logic [MV_W-1:0]    empty_mv;
    logic [MV_W-1:0]    low_mv;
    logic [MV_W-1:0]    critical_mv;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_CONV,
    ST_PCT,
    ST_DIV,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load_sample;
    logic mul_en;
    logic conv_en;
    logic pct_load;
    logic div_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic need_div;
  } status_t;

endpackage

// ===== hdl/bga_sample_if.sv =====
// Input channel carrying one raw converter sample per word.
interface bga_sample_if;
  logic                         valid;
  logic                         ready;
  logic [bga_pkg::ADC_BITS-1:0] adc_sample;

  modport source (output valid, output adc_sample, input ready);
  modport sink (input valid, input adc_sample, output ready);
endinterface

// ===== hdl/bga_result_if.sv =====
// Output channel carrying one gauge result per word.
interface bga_result_if;
  logic                      valid;
  logic                      ready;
  logic [bga_pkg::MV_W-1:0]  battery_mv;
  logic [bga_pkg::PCT_W-1:0] charge_percent;
  logic                      low_flag;
  logic                      critical_flag;

  modport source (output valid, output battery_mv, output charge_percent,
                  output low_flag, output critical_flag, input ready);
  modport sink (input valid, input battery_mv, input charge_percent,
                input low_flag, input critical_flag, output ready);
endinterface

// ===== hdl/battery_gauge_averager_unit.sv =====
// Top level of the battery gauge averager: config registers, controller and datapath.
//
// Each accepted sample word enters an eight-entry ring whose running sum gives the
// window average; the average is scaled to millivolts (saturating at 16383), turned
// into a 0..100 charge percentage between the empty and full thresholds, and flagged
// against the low and critical thresholds. One result word leaves per sample. A
// sample passes through the multiply, convert and percent states; inside the linear
// band a restoring divider then produces one of 21 quotient bits per cycle.
// The next sample is accepted as soon as the controller is back in idle, even while
// the previous result word still waits in the output register. The sample ring and
// window sum start at zero after reset, so the first seven averages include zeros.
module battery_gauge_averager_unit (
  input  logic                            clk,
  input  logic                            rst,
  bga_sample_if.sink                      sample,
  bga_result_if.source                    result,
  input  logic                            cfg_we,
  input  logic [bga_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bga_pkg::CFG_DATA_W-1:0]  cfg_data
);

  bga_pkg::cfg_t     cfg;
  bga_pkg::cmd_t     cmd;
  bga_pkg::status_t  status;

  bga_cfg u_cfg (
    .clk   (clk),
    .rst   (rst),
    .we    (cfg_we),
    .index (cfg_index),
    .data  (cfg_data),
    .cfg   (cfg)
  );

  bga_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sample.valid),
    .in_ready  (sample.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .status    (status),
    .cmd       (cmd)
  );

  bga_dpath u_dpath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .cfg            (cfg),
    .adc_sample     (sample.adc_sample),
    .status         (status),
    .battery_mv     (result.battery_mv),
    .charge_percent (result.charge_percent),
    .low_flag       (result.low_flag),
    .critical_flag  (result.critical_flag)
  );

endmodule

// ===== hdl/bga_cfg.sv =====
// Configuration register file with the precomputed voltage scale factor.
module bga_cfg (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              we,
  input  logic [bga_pkg::CFG_IDX_W-1:0]     index,
  input  logic [bga_pkg::CFG_DATA_W-1:0]    data,
  output bga_pkg::cfg_t                     cfg
);

  localparam logic [bga_pkg::SCALE_W-1:0] SCALE_RESET =
    bga_pkg::SCALE_W'(bga_pkg::VREF_MV * int'(bga_pkg::DIVIDER_RESET));

  logic [bga_pkg::SCALE_W-1:0] scale_new;

  assign scale_new = bga_pkg::SCALE_W'(bga_pkg::VREF_MV *
                                       int'(data[bga_pkg::DIVR_W-1:0]));

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.scale         <= SCALE_RESET;
      cfg.full_mv       <= bga_pkg::FULL_RESET;
      cfg.empty_mv      <= bga_pkg::EMPTY_RESET;
      cfg.low_mv        <= bga_pkg::LOW_RESET;
      cfg.critical_mv   <= bga_pkg::CRITICAL_RESET;
    end else if (we) begin
      unique case (index)
        bga_pkg::REG_DIVIDER:  cfg.scale       <= scale_new;
        bga_pkg::REG_FULL:     cfg.full_mv     <= data;
        bga_pkg::REG_EMPTY:    cfg.empty_mv    <= data;
        bga_pkg::REG_LOW:      cfg.low_mv      <= data;
        bga_pkg::REG_CRITICAL: cfg.critical_mv <= data;
        default: ;
      endcase
    end
  end

endmodule

// ===== hdl/bga_ctrl.sv =====
// Sequencing state machine for the averaging, conversion and percent division.
module bga_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  bga_pkg::status_t  status,
  output bga_pkg::cmd_t     cmd
);

  localparam logic [bga_pkg::CNT_W-1:0] CNT_LAST = bga_pkg::CNT_W'(bga_pkg::DIV_STEPS - 1);

  bga_pkg::state_t            state;
  bga_pkg::state_t            state_next;
  logic [bga_pkg::CNT_W-1:0]  cnt;
  logic                       out_free;

  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    unique case (state)
      bga_pkg::ST_IDLE:   if (in_valid) state_next = bga_pkg::ST_MUL;
      bga_pkg::ST_MUL:    state_next = bga_pkg::ST_CONV;
      bga_pkg::ST_CONV:   state_next = bga_pkg::ST_PCT;
      bga_pkg::ST_PCT: begin
        state_next = status.need_div ? bga_pkg::ST_DIV : bga_pkg::ST_FINISH;
      end
      bga_pkg::ST_DIV:    if (cnt == CNT_LAST) state_next = bga_pkg::ST_FINISH;
      bga_pkg::ST_FINISH: if (out_free) state_next = bga_pkg::ST_IDLE;
      default:            state_next = bga_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready        = (state == bga_pkg::ST_IDLE);
    cmd.load_sample = (state == bga_pkg::ST_IDLE) && in_valid;
    cmd.mul_en      = (state == bga_pkg::ST_MUL);
    cmd.conv_en     = (state == bga_pkg::ST_CONV);
    cmd.pct_load    = (state == bga_pkg::ST_PCT);
    cmd.div_step    = (state == bga_pkg::ST_DIV);
    cmd.out_load    = (state == bga_pkg::ST_FINISH) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= bga_pkg::ST_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.pct_load) begin
        cnt <= '0;
      end else if (cmd.div_step) begin
        cnt <= cnt + 1'b1;
      end
      // The result word is held until taken; a new one only lands in a free slot.
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_accept_starts_mul: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == bga_pkg::ST_MUL))
    else $error("accepted sample did not start the multiply step");

  a_div_ends: assert property (@(posedge clk) disable iff (rst)
    (state == bga_pkg::ST_DIV && cnt == CNT_LAST) |=> (state == bga_pkg::ST_FINISH))
    else $error("division did not end after the last step");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("pending result word was dropped");

endmodule

// ===== hdl/bga_dpath.sv =====
// Datapath: sample ring, window sum, millivolt conversion, percent divider, result register.
module bga_dpath (
  input  logic                          clk,
  input  logic                          rst,
  input  bga_pkg::cmd_t                 cmd,
  input  bga_pkg::cfg_t                 cfg,
  input  logic [bga_pkg::ADC_BITS-1:0]  adc_sample,
  output bga_pkg::status_t              status,
  output logic [bga_pkg::MV_W-1:0]      battery_mv,
  output logic [bga_pkg::PCT_W-1:0]     charge_percent,
  output logic                          low_flag,
  output logic                          critical_flag
);

  // Division by 4095 is done as x = q0*4096 + lo = q0*4095 + (lo + q0), folded twice.
  localparam int Q0_W = bga_pkg::PROD_W - bga_pkg::ADC_BITS;
  localparam int R0_W = Q0_W + 1;
  localparam int Q1_W = R0_W - bga_pkg::ADC_BITS;
  localparam int R1_W = bga_pkg::ADC_BITS + 1;
  localparam int Q_W  = Q0_W + 1;

  logic [bga_pkg::ADC_BITS-1:0]  ring [bga_pkg::WINDOW];
  logic [bga_pkg::WIN_LOG2-1:0]  slot;
  logic [bga_pkg::SUM_W-1:0]     sum;
  logic [bga_pkg::SUM_W-1:0]     sum_next;
  logic [bga_pkg::ADC_BITS-1:0]  avg;
  logic [bga_pkg::PROD_W-1:0]    prod;

  logic [Q0_W-1:0]               q0;
  logic [R0_W-1:0]               r0;
  logic [Q1_W-1:0]               q1;
  logic [R1_W-1:0]               r1;
  logic                          corr;
  logic [Q_W-1:0]                q;
  logic [bga_pkg::MV_W-1:0]      mv_sat;
  logic [bga_pkg::MV_W-1:0]      mv;

  logic                          at_full;
  logic                          at_empty;
  logic [bga_pkg::DVD_W-1:0]     dividend;
  logic [bga_pkg::DVD_W-1:0]     quo;
  logic [bga_pkg::REM_W-1:0]     rem;
  logic [bga_pkg::MV_W-1:0]      dsr;
  logic [bga_pkg::REM_W-1:0]     shifted;
  logic [bga_pkg::REM_W:0]       trial;

  assign sum_next = sum - bga_pkg::SUM_W'(ring[slot]) + bga_pkg::SUM_W'(adc_sample);
  assign avg      = sum[bga_pkg::SUM_W-1:bga_pkg::WIN_LOG2];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < bga_pkg::WINDOW; i++) begin
        ring[i] <= '0;
      end
      slot <= '0;
      sum  <= '0;
    end else if (cmd.load_sample) begin
      ring[slot] <= adc_sample;
      slot       <= slot + 1'b1;
      sum        <= sum_next;
    end
  end

  always_comb begin
    q0     = prod[bga_pkg::PROD_W-1:bga_pkg::ADC_BITS];
    r0     = R0_W'(prod[bga_pkg::ADC_BITS-1:0]) + R0_W'(q0);
    q1     = r0[R0_W-1:bga_pkg::ADC_BITS];
    r1     = R1_W'(r0[bga_pkg::ADC_BITS-1:0]) + R1_W'(q1);
    corr   = (r1 >= R1_W'(bga_pkg::SAMPLE_MAX));
    q      = Q_W'(q0) + Q_W'(q1) + Q_W'(corr);
    mv_sat = (q > Q_W'(bga_pkg::MV_MAX)) ? bga_pkg::MV_W'(bga_pkg::MV_MAX)
                                         : q[bga_pkg::MV_W-1:0];
  end

  always_comb begin
    at_full         = (mv >= cfg.full_mv);
    at_empty        = (mv <= cfg.empty_mv);
    status.need_div = !at_full && !at_empty;
    dividend        = bga_pkg::DVD_W'(mv - cfg.empty_mv) *
                      bga_pkg::DVD_W'(bga_pkg::FULL_PERCENT);
    shifted         = {rem[bga_pkg::REM_W-2:0], quo[bga_pkg::DVD_W-1]};
    trial           = {1'b0, shifted} - (bga_pkg::REM_W + 1)'(dsr);
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod <= bga_pkg::PROD_W'(avg) * bga_pkg::PROD_W'(cfg.scale);
    end
    if (cmd.conv_en) begin
      mv <= mv_sat;
    end
    // Outside the linear band the quotient register simply holds the fixed percent.
    if (cmd.pct_load) begin
      rem <= '0;
      dsr <= cfg.full_mv - cfg.empty_mv;
      if (status.need_div) begin
        quo <= dividend;
      end else if (at_full) begin
        quo <= bga_pkg::DVD_W'(bga_pkg::FULL_PERCENT);
      end else begin
        quo <= '0;
      end
    end else if (cmd.div_step) begin
      if (!trial[bga_pkg::REM_W]) begin
        rem <= trial[bga_pkg::REM_W-1:0];
        quo <= {quo[bga_pkg::DVD_W-2:0], 1'b1};
      end else begin
        rem <= shifted;
        quo <= {quo[bga_pkg::DVD_W-2:0], 1'b0};
      end
    end
    if (cmd.out_load) begin
      battery_mv     <= mv;
      charge_percent <= quo[bga_pkg::PCT_W-1:0];
      low_flag       <= (mv != '0) && (mv <= cfg.low_mv);
      critical_flag  <= (mv != '0) && (mv <= cfg.critical_mv);
    end
  end

  a_pct_range: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> (charge_percent <= bga_pkg::PCT_W'(bga_pkg::FULL_PERCENT)))
    else $error("charge percent above full scale");

  a_zero_no_flags: assert property (@(posedge clk) disable iff (rst)
    (cmd.out_load && mv == '0) |=> (!low_flag && !critical_flag))
    else $error("flag raised for a zero voltage");

endmodule
